// ===== rtl/erpx_pkg.sv =====
package erpx_pkg;

  localparam int DEF_COORD_WIDTH    = 24;
  localparam int DEF_TRIG_FRAC_BITS = 15;

  localparam int ANGLE_BITS = 10;
  localparam int DEG_BITS   = 9;   // reduced angle, 0..359
  localparam int ROM_DEPTH  = 91;  // quarter wave, 0..90 degrees
  localparam int ROM_IDX_W  = $clog2(ROM_DEPTH);

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ANGLE_X = 2'd0;
  localparam logic [1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [1:0] REG_ANGLE_Z = 2'd2;

  localparam logic [63:0] PI_Q31 = 64'd6746518852;

  typedef struct packed {
    logic                 neg;
    logic [ROM_IDX_W-1:0] idx;
  } fold_t;

  // Q31 product, truncated.
  function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 31;
  endfunction

  // Quarter-wave sine entry, Taylor series at Q31, rounded to frac bits.
  // Used only at elaboration to fill the ROM.
  function automatic logic [63:0] quarter_sin(input int d, input int frac);
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] one;
    int          sh;
    one = 64'd1 << frac;
    if (d <= 0) begin
      return 64'd0;
    end
    if (d >= 90) begin
      return one;
    end
    r    = (64'(d) * PI_Q31 + 64'd90) / 64'd180;
    term = r;
    sum  = r;
    // eleven terms after the first, sign alternating, each from the previous one
    term = mul_q31(term, r) / 64'd2;  term = mul_q31(term, r) / 64'd3;  sum = sum - term;
    term = mul_q31(term, r) / 64'd4;  term = mul_q31(term, r) / 64'd5;  sum = sum + term;
    term = mul_q31(term, r) / 64'd6;  term = mul_q31(term, r) / 64'd7;  sum = sum - term;
    term = mul_q31(term, r) / 64'd8;  term = mul_q31(term, r) / 64'd9;  sum = sum + term;
    term = mul_q31(term, r) / 64'd10; term = mul_q31(term, r) / 64'd11; sum = sum - term;
    term = mul_q31(term, r) / 64'd12; term = mul_q31(term, r) / 64'd13; sum = sum + term;
    term = mul_q31(term, r) / 64'd14; term = mul_q31(term, r) / 64'd15; sum = sum - term;
    term = mul_q31(term, r) / 64'd16; term = mul_q31(term, r) / 64'd17; sum = sum + term;
    term = mul_q31(term, r) / 64'd18; term = mul_q31(term, r) / 64'd19; sum = sum - term;
    term = mul_q31(term, r) / 64'd20; term = mul_q31(term, r) / 64'd21; sum = sum + term;
    term = mul_q31(term, r) / 64'd22; term = mul_q31(term, r) / 64'd23; sum = sum - term;
    sh  = 31 - frac;
    sum = (sum + (64'd1 << (sh - 1))) >> sh;
    if (sum > one) begin
      sum = one;
    end
    return sum;
  endfunction

  // Fold a 0..359 degree angle onto the quarter-wave table for sine.
  function automatic fold_t fold_sin(input logic [DEG_BITS-1:0] a);
    fold_t f;
    logic [DEG_BITS-1:0] t;
    t = '0;
    f.neg = 1'b0;
    if (a <= DEG_BITS'(90)) begin
      t = a;
    end else if (a <= DEG_BITS'(180)) begin
      t = DEG_BITS'(180) - a;
    end else if (a <= DEG_BITS'(270)) begin
      t = a - DEG_BITS'(180);
      f.neg = 1'b1;
    end else begin
      t = DEG_BITS'(360) - a;
      f.neg = 1'b1;
    end
    f.idx = t[ROM_IDX_W-1:0];
    return f;
  endfunction

endpackage

// ===== rtl/erpx_point_if.sv =====
interface erpx_point_if
  import erpx_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface erpx_result_if
  import erpx_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rotated_x;
  logic signed [COORD_WIDTH-1:0] rotated_y;
  logic signed [COORD_WIDTH-1:0] rotated_z;
  logic                          saturated;

  modport source (output valid, rotated_x, rotated_y, rotated_z, saturated, input ready);
  modport sink   (input valid, rotated_x, rotated_y, rotated_z, saturated, output ready);
endinterface

// ===== rtl/erpx_trig.sv =====
module erpx_trig
  import erpx_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
  input  logic                           clk,
  input  logic signed [ANGLE_BITS-1:0]   angle,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_val,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_val
);

  localparam int MAG_W  = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;

  logic [MAG_W-1:0] rom [0:ROM_DEPTH-1];

  for (genvar d = 0; d < ROM_DEPTH; d++) begin : g_rom
    localparam logic [MAG_W-1:0] ENTRY = MAG_W'(quarter_sin(d, TRIG_FRAC_BITS));
    assign rom[d] = ENTRY;
  end

  logic signed [ANGLE_BITS:0] a0;
  logic signed [ANGLE_BITS:0] a1;
  logic signed [ANGLE_BITS:0] a2;
  logic [DEG_BITS-1:0]        deg;
  logic [DEG_BITS:0]          deg_c_wide;
  logic [DEG_BITS-1:0]        deg_c;
  fold_t                      fs;
  fold_t                      fc;
  logic signed [TRIG_W-1:0]   sin_next;
  logic signed [TRIG_W-1:0]   cos_next;

  // reduce to 0..359
  always_comb begin
    a0 = (ANGLE_BITS+1)'(angle);
    if (a0 < 0) begin
      a1 = a0 + (ANGLE_BITS+1)'(360);
    end else if (a0 >= (ANGLE_BITS+1)'(360)) begin
      a1 = a0 - (ANGLE_BITS+1)'(360);
    end else begin
      a1 = a0;
    end
    if (a1 < 0) begin
      a2 = a1 + (ANGLE_BITS+1)'(360);
    end else begin
      a2 = a1;
    end
    deg        = a2[DEG_BITS-1:0];
    deg_c_wide = {1'b0, deg} + (DEG_BITS+1)'(90);
    if (deg_c_wide >= (DEG_BITS+1)'(360)) begin
      deg_c = DEG_BITS'(deg_c_wide - (DEG_BITS+1)'(360));
    end else begin
      deg_c = deg_c_wide[DEG_BITS-1:0];
    end
    fs = fold_sin(deg);
    fc = fold_sin(deg_c);
    sin_next = fs.neg ? -$signed({1'b0, rom[fs.idx]}) : $signed({1'b0, rom[fs.idx]});
    cos_next = fc.neg ? -$signed({1'b0, rom[fc.idx]}) : $signed({1'b0, rom[fc.idx]});
  end

  always_ff @(posedge clk) begin
    sin_val <= sin_next;
    cos_val <= cos_next;
  end

endmodule

// ===== rtl/erpx_rot_stage.sv =====
module erpx_rot_stage
  import erpx_pkg::*;
#(
  parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
  parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_val,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COORD_WIDTH-1:0]    in_u,
  input  logic signed [COORD_WIDTH-1:0]    in_v,
  input  logic signed [COORD_WIDTH-1:0]    in_w,
  input  logic                             in_sat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [COORD_WIDTH-1:0]    out_u,
  output logic signed [COORD_WIDTH-1:0]    out_v,
  output logic signed [COORD_WIDTH-1:0]    out_w,
  output logic                             out_sat
);

  // u' = c*u - s*v, v' = s*u + c*v
  localparam int SW = COORD_WIDTH + TRIG_FRAC_BITS + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] CMAX = {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  // product stage
  logic                          mul_vld;
  logic                          mul_rdy;
  logic signed [SW-1:0]          uc;
  logic signed [SW-1:0]          vs;
  logic signed [SW-1:0]          us;
  logic signed [SW-1:0]          vc;
  logic signed [COORD_WIDTH-1:0] mul_w;
  logic                          mul_sat;

  // round and clamp
  logic                          out_rdy;
  logic signed [SW-1:0]          sum_u;
  logic signed [SW-1:0]          sum_v;
  logic signed [SW-1:0]          shr_u;
  logic signed [SW-1:0]          shr_v;
  logic                          clip_u;
  logic                          clip_v;
  logic signed [COORD_WIDTH-1:0] u_next;
  logic signed [COORD_WIDTH-1:0] v_next;

  assign out_rdy  = !out_valid || out_ready;
  assign mul_rdy  = !mul_vld || out_rdy;
  assign in_ready = mul_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else if (mul_rdy) begin
      mul_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_rdy && in_valid) begin
      uc      <= SW'(in_u) * SW'(cos_val);
      vs      <= SW'(in_v) * SW'(sin_val);
      us      <= SW'(in_u) * SW'(sin_val);
      vc      <= SW'(in_v) * SW'(cos_val);
      mul_w   <= in_w;
      mul_sat <= in_sat;
    end
  end

  always_comb begin
    sum_u  = uc - vs + HALF;
    sum_v  = us + vc + HALF;
    shr_u  = sum_u >>> TRIG_FRAC_BITS;
    shr_v  = sum_v >>> TRIG_FRAC_BITS;
    clip_u = (shr_u > CMAX) || (shr_u < CMIN);
    clip_v = (shr_v > CMAX) || (shr_v < CMIN);
    if (shr_u > CMAX) begin
      u_next = CMAX[COORD_WIDTH-1:0];
    end else if (shr_u < CMIN) begin
      u_next = CMIN[COORD_WIDTH-1:0];
    end else begin
      u_next = shr_u[COORD_WIDTH-1:0];
    end
    if (shr_v > CMAX) begin
      v_next = CMAX[COORD_WIDTH-1:0];
    end else if (shr_v < CMIN) begin
      v_next = CMIN[COORD_WIDTH-1:0];
    end else begin
      v_next = shr_v[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_rdy) begin
      out_valid <= mul_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && mul_vld) begin
      out_u   <= u_next;
      out_v   <= v_next;
      out_w   <= mul_w;
      out_sat <= mul_sat || clip_u || clip_v;
    end
  end

endmodule

// ===== rtl/euler_rotate_point_xyz_unit.sv =====
// Euler rotation of a 3D point: about x, then y, then z, by three angles
// in whole degrees held in configuration registers.
//
// Channels: "point" takes one (point_x, point_y, point_z) transaction per
// valid/ready handshake; "result" returns one (rotated_x, rotated_y,
// rotated_z, saturated) transaction for each point, in order. Coordinates
// are signed fixed point; saturated flags clipping in any axis stage.
// Configuration: APB registers at byte offsets 0x0 (x), 0x4 (y), 0x8 (z),
// 10-bit signed degrees, any value reduced modulo 360. Write them while no
// transaction is in flight; sine/cosine are registered in the next cycle.
//
// Each axis stage is a product register then a round/clamp register.
// Throughput is one point per cycle while the receiver is ready. Each
// stage register holds its own valid bit and advances whenever the stage
// after it is empty or moving, so bubbles collapse and a stalled receiver
// backs up the pipe one stage at a time; nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits and sets all angles to 0,
// which rotates by cos 1, sin 0 and passes points unchanged.
module euler_rotate_point_xyz_unit
  import erpx_pkg::*;
#(
  parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
  parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  erpx_point_if.sink            point,
  erpx_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [ANGLE_BITS-1:0] angle_x;
  logic signed [ANGLE_BITS-1:0] angle_y;
  logic signed [ANGLE_BITS-1:0] angle_z;
  logic                         wr_en;
  logic [1:0]                   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x <= '0;
      angle_y <= '0;
      angle_z <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ANGLE_X: angle_x <= pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_Y: angle_y <= pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_Z: angle_z <= pwdata[ANGLE_BITS-1:0];
        default: ;  // unmapped offset: drop the write
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ANGLE_X: prdata = APB_DATA_W'(angle_x);
      REG_ANGLE_Y: prdata = APB_DATA_W'(angle_y);
      REG_ANGLE_Z: prdata = APB_DATA_W'(angle_z);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // sine/cosine per axis, registered from the angle registers
  // ---------------------------------------------------------------------
  logic signed [TRIG_W-1:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;

  erpx_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_x (
    .clk(clk), .angle(angle_x), .cos_val(cos_x), .sin_val(sin_x)
  );
  erpx_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_y (
    .clk(clk), .angle(angle_y), .cos_val(cos_y), .sin_val(sin_y)
  );
  erpx_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_z (
    .clk(clk), .angle(angle_z), .cos_val(cos_z), .sin_val(sin_z)
  );

  // ---------------------------------------------------------------------
  // datapath: x stage rotates (y, z), y stage rotates (z, x), z stage (x, y)
  // ---------------------------------------------------------------------
  logic                          vld1, rdy1, vld2, rdy2;
  logic signed [COORD_WIDTH-1:0] x1, y1, z1, x2, y2, z2;
  logic                          sat1, sat2;

  erpx_rot_stage #(
    .COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rot_x (
    .clk(clk), .rst(rst),
    .cos_val(cos_x), .sin_val(sin_x),
    .in_valid(point.valid), .in_ready(point.ready),
    .in_u(point.point_y), .in_v(point.point_z), .in_w(point.point_x),
    .in_sat(1'b0),
    .out_valid(vld1), .out_ready(rdy1),
    .out_u(y1), .out_v(z1), .out_w(x1), .out_sat(sat1)
  );

  erpx_rot_stage #(
    .COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rot_y (
    .clk(clk), .rst(rst),
    .cos_val(cos_y), .sin_val(sin_y),
    .in_valid(vld1), .in_ready(rdy1),
    .in_u(z1), .in_v(x1), .in_w(y1), .in_sat(sat1),
    .out_valid(vld2), .out_ready(rdy2),
    .out_u(z2), .out_v(x2), .out_w(y2), .out_sat(sat2)
  );

  erpx_rot_stage #(
    .COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rot_z (
    .clk(clk), .rst(rst),
    .cos_val(cos_z), .sin_val(sin_z),
    .in_valid(vld2), .in_ready(rdy2),
    .in_u(x2), .in_v(y2), .in_w(z2), .in_sat(sat2),
    .out_valid(result.valid), .out_ready(result.ready),
    .out_u(result.rotated_x), .out_v(result.rotated_y),
    .out_w(result.rotated_z), .out_sat(result.saturated)
  );

endmodule

// ===== tb/sv/rotate_checker.sv =====
`timescale 1ns / 1ps

module rotate_checker
  import erpx_pkg::*;
#(
  parameter int CW = DEF_COORD_WIDTH,
  parameter int TF = DEF_TRIG_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  erpx_point_if                 points,
  erpx_result_if                results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  output int                    errors,
  output int                    outstanding
);

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } rotated_t;

  logic signed [ANGLE_BITS-1:0] ang_x;
  logic signed [ANGLE_BITS-1:0] ang_y;
  logic signed [ANGLE_BITS-1:0] ang_z;

  longint   sine_tab [0:90];
  rotated_t expected_rotations [$];

  // Quarter-wave sine at TF fraction bits, from a truncating Taylor series at 2^31.
  function automatic longint taylor_sine(input int d);
    longint unsigned r;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned unity;
    unity = 64'd1 << TF;
    if (d == 0) return 0;
    if (d == 90) return longint'(unity);
    r    = (64'(d) * PI_Q31 + 64'd90) / 64'd180;
    term = r;
    acc  = r;
    for (int k = 1; k <= 11; k++) begin
      term = ((term * r) >> 31) / 64'(2 * k);
      term = ((term * r) >> 31) / 64'(2 * k + 1);
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    acc = (acc + (64'd1 << (30 - TF))) >> (31 - TF);
    if (acc > unity) acc = unity;
    return longint'(acc);
  endfunction

  initial begin
    for (int d = 0; d <= 90; d++) sine_tab[d] = taylor_sine(d);
  end

  function automatic longint folded_sine(input int a);
    if (a <= 90) return sine_tab[a];
    if (a <= 180) return sine_tab[180 - a];
    if (a <= 270) return -sine_tab[a - 180];
    return -sine_tab[360 - a];
  endfunction

  function automatic void stage_trig(input int deg, output longint c, output longint s);
    int a;
    a = ((deg % 360) + 360) % 360;
    s = folded_sine(a);
    c = folded_sine((a + 90) % 360);
  endfunction

  // a*p + b*q, round half up, then clamp to the coordinate range
  function automatic longint round_clamp(input longint a, input longint p,
                                         input longint b, input longint q,
                                         inout logic sat);
    longint v;
    longint lim;
    lim = longint'(1) << (CW - 1);
    v   = (a * p + b * q + (longint'(1) << (TF - 1))) >>> TF;
    if (v > lim - 1) begin
      sat = 1'b1;
      return lim - 1;
    end
    if (v < -lim) begin
      sat = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  function automatic rotated_t predict_rotation(input coord_t px, input coord_t py,
                                                input coord_t pz);
    longint   x, y, z, c, s, t1, t2;
    logic     sat;
    rotated_t r;
    x   = px;
    y   = py;
    z   = pz;
    sat = 1'b0;
    if (ang_x != 0) begin
      stage_trig(ang_x, c, s);
      t1 = round_clamp(c, y, -s, z, sat);
      t2 = round_clamp(s, y, c, z, sat);
      y  = t1;
      z  = t2;
    end
    if (ang_y != 0) begin
      stage_trig(ang_y, c, s);
      t1 = round_clamp(c, x, s, z, sat);
      t2 = round_clamp(c, z, -s, x, sat);
      x  = t1;
      z  = t2;
    end
    if (ang_z != 0) begin
      stage_trig(ang_z, c, s);
      t1 = round_clamp(c, x, -s, y, sat);
      t2 = round_clamp(s, x, c, y, sat);
      x  = t1;
      y  = t2;
    end
    r.x   = coord_t'(x);
    r.y   = coord_t'(y);
    r.z   = coord_t'(z);
    r.sat = sat;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t rotate_checker: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    rotated_t                     want;
    logic signed [ANGLE_BITS-1:0] held;
    logic                         known;
    if (rst) begin
      ang_x       = '0;
      ang_y       = '0;
      ang_z       = '0;
      errors      = 0;
      outstanding = 0;
      expected_rotations.delete();
    end else begin
      if (psel && penable && pready) begin
        known = 1'b1;
        held  = '0;
        case (paddr[3:2])
          REG_ANGLE_X: held = ang_x;
          REG_ANGLE_Y: held = ang_y;
          REG_ANGLE_Z: held = ang_z;
          default:     known = 1'b0;
        endcase
        if (pwrite) begin
          case (paddr[3:2])
            REG_ANGLE_X: ang_x = pwdata[ANGLE_BITS-1:0];
            REG_ANGLE_Y: ang_y = pwdata[ANGLE_BITS-1:0];
            REG_ANGLE_Z: ang_z = pwdata[ANGLE_BITS-1:0];
            default:     ;
          endcase
        end else if (known) begin
          check_field("angle readback", held, $signed(prdata[ANGLE_BITS-1:0]));
        end
      end
      if (points.valid && points.ready) begin
        expected_rotations.push_back(predict_rotation(points.point_x, points.point_y,
                                                      points.point_z));
        outstanding++;
      end
      if (results.valid && results.ready) begin
        if (expected_rotations.size() == 0) begin
          errors++;
          $display("%0t rotate_checker: result with nothing outstanding, actual %0d %0d %0d %0b",
                   $time, results.rotated_x, results.rotated_y, results.rotated_z,
                   results.saturated);
        end else begin
          want = expected_rotations.pop_front();
          outstanding--;
          check_field("rotated_x", want.x, results.rotated_x);
          check_field("rotated_y", want.y, results.rotated_y);
          check_field("rotated_z", want.z, results.rotated_z);
          check_field("saturated", want.sat, results.saturated);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import erpx_pkg::*;

  localparam int CW = DEF_COORD_WIDTH;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  // no register decodes at this index
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PHASES   = 16;
  localparam int PHASE_ITEMS     = 100;

  logic clk;
  logic rst;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int errors;
  int outstanding;

  // shared between the point sender and the result drain
  bit idle_on      = 1'b1;
  bit hold_off_req = 1'b0;

  erpx_point_if  #(.COORD_WIDTH(CW)) points ();
  erpx_result_if #(.COORD_WIDTH(CW)) results ();

  euler_rotate_point_xyz_unit dut (
    .clk     (clk),
    .rst     (rst),
    .point   (points),
    .result  (results),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rotate_checker #(.CW(CW)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .points      (points),
    .results     (results),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: report failure if the run has not finished first.
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  // Gap length: lowest of three ranges 70% of draws, middle 25%, top 5%.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Mix corner values, small magnitudes and full-range random coordinates.
  function automatic logic signed [CW-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 4))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          3:       return '1;
          default: return CW'(1);
        endcase
      end
      1, 2, 3: return CW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return CW'($urandom());
    endcase
  endfunction

  // Angles: some zero, some at the edges of the register, the rest anywhere
  // in the 10-bit range.
  function automatic int rand_angle();
    int edge_angles [10] = '{360, -360, 359, -359, 511, -512, 90, -90, 180, 270};
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r == 2) return edge_angles[$urandom_range(0, 9)];
    return $urandom_range(0, 1023) - 512;
  endfunction

  function automatic logic [APB_ADDR_W-1:0] reg_addr(input logic [1:0] idx);
    return {idx, 2'b00};
  endfunction

  // Setup phase, then access until pready; then deassert psel and idle so
  // back-to-back transfers never overlap on psel.
  task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                              input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= reg_addr(idx);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Put the angle in the low 10 bits; random upper bits must be dropped.
  task automatic write_angle(input logic [1:0] idx, input int deg);
    logic [APB_DATA_W-1:0] data;
    data                 = $urandom();
    data[ANGLE_BITS-1:0] = deg[ANGLE_BITS-1:0];
    apb_transfer(1'b1, idx, data);
  endtask

  // Drop valid and hold until the checker has every result back.
  task automatic drain_pipe();
    points.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Reconfigure only with the pipe empty, read back, then let the
  // registered sine/cosine settle before the next point.
  task automatic set_angles(input int ax, input int ay, input int az);
    drain_pipe();
    write_angle(REG_ANGLE_X, ax);
    write_angle(REG_ANGLE_Y, ay);
    write_angle(REG_ANGLE_Z, az);
    apb_transfer(1'b0, REG_ANGLE_X, '0);
    apb_transfer(1'b0, REG_ANGLE_Y, '0);
    apb_transfer(1'b0, REG_ANGLE_Z, '0);
    repeat (4) @(posedge clk);
  endtask

  // Offer one point and hold it until accepted; then maybe idle a while.
  task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                            input logic signed [CW-1:0] z);
    points.valid   <= 1'b1;
    points.point_x <= x;
    points.point_y <= y;
    points.point_z <= z;
    do @(posedge clk); while (!points.ready);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      points.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic send_random_point();
    send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  // Result drain: random stalls, plus one long hold-off on request so the
  // pipe fills and pushes back on the point channel.
  initial begin : result_drain
    results.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        results.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        results.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      results.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    points.valid   <= 1'b0;
    points.point_x <= '0;
    points.point_y <= '0;
    points.point_z <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset angles: cos 1, sin 0 in every stage, points pass through bit-exact.
    send_point(C_MAX, C_MIN, '0);
    send_point(C_MIN, C_MAX, '1);
    send_point(CW'(1), '1, CW'(12345));

    // Quarter turn about x: y' = -z clips when z is the most negative value.
    set_angles(90, 0, 0);
    send_point(C_MAX, C_MAX, C_MIN);
    send_point(CW'(32'h10000), CW'(32'h10000), CW'(-32'h10000));

    set_angles(0, -90, 180);
    send_point(C_MIN, CW'(777), C_MAX);
    send_point(CW'(-5), C_MIN, CW'(3));

    // Nonzero registers that reduce to zero degrees: cos 1, sin 0, no change.
    set_angles(360, -360, 0);
    send_point(C_MAX, C_MIN, C_MAX);
    send_point(CW'(-123456), CW'(654321), '1);

    // 45 degrees on every axis with full-scale inputs drives the x and y
    // stages into saturation.
    set_angles(45, 45, 45);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);

    // Register extremes, plus a write to an index that decodes to nothing.
    set_angles(511, -512, 359);
    apb_transfer(1'b1, REG_UNUSED, $urandom());
    send_point(C_MAX, '0, C_MIN);
    send_point(CW'(1), CW'(-1), CW'(1));

    set_angles(-359, 1, -1);
    send_point(C_MIN, C_MAX, CW'(65536));
    send_point(CW'(40000), CW'(-40000), CW'(0));

    set_angles(270, 180, 90);
    send_point(C_MAX, CW'(-7), C_MIN);
    send_point(CW'(99999), C_MAX, CW'(-99999));

    // Random phases: fresh angles each time; some phases run without idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_angles(rand_angle(), rand_angle(), rand_angle());
      idle_on = ($urandom_range(0, 2) != 0);
      // Stall the receiver for a long stretch while points keep coming.
      if (ph == 2) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender mid-phase until every result is back.
        if (ph == 5 && n == PHASE_ITEMS / 2) drain_pipe();
        send_random_point();
      end
    end

    points.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
